### hdl/rtpaf_pkg.sv
// shared types, codes and constants of the rtp access unit fragmenter
`timescale 1ns / 1ps

package rtpaf_pkg;

    localparam int unsigned SIZE_W  = 31;
    localparam int unsigned MP_W    = 16;
    localparam int unsigned CNT_W   = 17;
    localparam int unsigned NUM_W   = 32;

    localparam logic [MP_W-1:0] MP_RESET  = 16'd1452;
    localparam logic [MP_W-1:0] HDR_BYTES = 16'd3;
    localparam logic [MP_W-1:0] MP_MIN    = 16'd7;

    localparam logic OP_BEGIN = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    localparam logic       MODE_SIMPLE = 1'b1;
    localparam logic [1:0] TYPE_MIDDLE = 2'd0;
    localparam logic [1:0] TYPE_LAST   = 2'd1;
    localparam logic [1:0] TYPE_FIRST  = 2'd2;

    // output byte selection
    localparam logic [2:0] OSEL_HDR0 = 3'd0;
    localparam logic [2:0] OSEL_HDR1 = 3'd1;
    localparam logic [2:0] OSEL_HDR2 = 3'd2;
    localparam logic [2:0] OSEL_SZ0  = 3'd3;
    localparam logic [2:0] OSEL_SZ1  = 3'd4;
    localparam logic [2:0] OSEL_SZ2  = 3'd5;
    localparam logic [2:0] OSEL_SZ3  = 3'd6;
    localparam logic [2:0] OSEL_DATA = 3'd7;

    typedef struct packed {
        logic       start_begin;
        logic       drop_begin;
        logic       finish_begin;
        logic       take_data;
        logic       out_load;
        logic       out_direct;
        logic [2:0] out_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic mp_small;
        logic div_done;
        logic count_ok;
        logic au_live;
        logic in_packet;
        logic out_free;
    } dp_stat_t;

    function automatic logic [7:0] hdr_byte(input logic [1:0] pkt_type);
        hdr_byte = {3'b000, MODE_SIMPLE, pkt_type, 2'b00};
    endfunction

endpackage

### hdl/rtp_au_fragmenter_core.sv
// top level of the rtp access unit fragmenter (simple-mode payload layout)
//
// input stream: tuser[0] is the item kind (0 begins an access unit, 1 is a
// data byte); tdata carries the unit size in [30:0] and the data byte in [38:31].
// output stream: one payload byte per beat, tuser[0] marks the first byte of
// a payload, tlast its last byte, tuser[1] the marker bit of the first payload.
// max_payload is written through cfg_we/cfg_wdata; the user must write it only
// while the block is idle, which the block itself does not enforce. a begin beat
// starts a bit-serial division for the packet count; its seven header and size
// bytes follow once the division is done. a data byte inside an open payload is
// accepted and loaded into the output register in the same cycle: one byte per
// cycle sustained while the receiver takes every beat. a data byte that opens a
// new payload holds off the input through its three header bytes, then the byte.
// a begin with max_payload of 7 or less, or needing over 65536 payloads,
// yields nothing; so does a data byte outside an access unit.
// when the receiver stalls, the output register holds its beat and the input
// side is held off until the register frees. reset clears all counters,
// loads max_payload with 1452 and empties the output register.
`timescale 1ns / 1ps

module rtp_au_fragmenter_core
    import rtpaf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // au_size[30:0], data_byte[38:31], zero pad
    input  logic [0:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic        m_tlast,
    output logic [1:0]  m_tuser,   // packet_start, marker
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;
    logic      out_start;
    logic      out_mark;

    rtpaf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_op    (s_tuser[0]),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rtpaf_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_size   (s_tdata[30:0]),
        .in_byte   (s_tdata[38:31]),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_start (out_start),
        .out_end   (m_tlast),
        .out_mark  (out_mark)
    );

    assign m_tuser = {out_mark, out_start};

    // an untaken beat is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("output register overwritten while holding a beat");

    // state-changing commands are mutually exclusive
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.start_begin, cmd.drop_begin, cmd.finish_begin, cmd.take_data}))
        else $error("conflicting datapath commands");

    // input commands only issue on an accepted beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.start_begin || cmd.drop_begin || cmd.take_data) |-> (s_tvalid && s_tready))
        else $error("input command without an accepted beat");

    // the count is only committed after the divider finishes
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish_begin |-> stat.div_done)
        else $error("packet count committed before division done");

endmodule

### hdl/rtpaf_divider.sv
// restoring divider, one quotient bit per cycle, for the packet count
`timescale 1ns / 1ps

module rtpaf_divider
    import rtpaf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [MP_W-1:0]  den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [MP_W-1:0]  rem_reg, rem_next;
    logic [MP_W-1:0]  den_reg, den_next;
    logic [MP_W:0]    trial;
    logic [MP_W:0]    diff;
    logic             fits;

    always_comb
    begin
        trial     = {rem_reg, quot_reg[NUM_W-1]};
        diff      = trial - {1'b0, den_reg};
        fits      = (trial >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quot_next = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[NUM_W-2:0], fits};
            // remainder stays below the divisor, so it fits in 16 bits
            rem_next  = fits ? diff[MP_W-1:0] : trial[MP_W-1:0];
            cnt_next  = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

### hdl/rtpaf_datapath.sv
// fragmenter datapath: counters, header values, size register and output register
`timescale 1ns / 1ps

module rtpaf_datapath
    import rtpaf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctrl_cmd_t         cmd,
    output dp_stat_t          stat,
    input  logic [SIZE_W-1:0] in_size,
    input  logic [7:0]        in_byte,
    input  logic              cfg_we,
    input  logic [MP_W-1:0]   cfg_wdata,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              out_start,
    output logic              out_end,
    output logic              out_mark
);

    logic [MP_W-1:0]   mp_reg;
    logic [CNT_W-1:0]  pl_reg;
    logic [MP_W-1:0]   chunk_reg;
    logic [SIZE_W-1:0] au_left_reg;
    logic              first_reg;
    logic              active_reg;
    logic              in_pkt_reg;

    logic [SIZE_W-1:0] size_reg;
    logic [MP_W-1:0]   mc_reg;
    logic [7:0]        hdr_b0_reg;
    logic [15:0]       hdr_cnt_reg;
    logic              hdr_mark_reg;
    logic [7:0]        data_reg;
    logic              data_end_reg;
    logic              data_mark_reg;

    logic              ovalid_reg;
    logic [7:0]        obyte_reg;
    logic              ostart_reg;
    logic              oend_reg;
    logic              omark_reg;

    logic [NUM_W-1:0]  div_num;
    logic [MP_W-1:0]   div_den;
    logic              div_done;
    logic [NUM_W-1:0]  quot;
    logic [NUM_W-1:0]  quot_m1;

    logic [MP_W-1:0]   cap;
    logic [MP_W-1:0]   au_min;
    logic [MP_W-1:0]   chunk_base;
    logic [MP_W-1:0]   chunk_nx;
    logic [SIZE_W-1:0] au_nx;
    logic [CNT_W-1:0]  pl_nx;
    logic              d_end;
    logic              d_mark;
    logic [MP_W-1:0]   cap_first;
    logic [MP_W-1:0]   chunk_first;

    logic [7:0]        sel_byte;
    logic              sel_start;
    logic              sel_end;
    logic              sel_mark;

    assign div_den = mp_reg - HDR_BYTES;
    assign div_num = {1'b0, in_size} + {16'd0, div_den} + 32'd3;

    rtpaf_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start_begin),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (quot)
    );

    always_comb
    begin
        cap        = (mp_reg > HDR_BYTES) ? (mp_reg - HDR_BYTES) : 16'd1;
        au_min     = (au_left_reg < {15'd0, cap}) ? au_left_reg[MP_W-1:0] : cap;
        chunk_base = in_pkt_reg ? chunk_reg : au_min;
        chunk_nx   = chunk_base - 16'd1;
        d_end      = (chunk_nx == '0);
        d_mark     = in_pkt_reg & first_reg;
        au_nx      = au_left_reg - 31'd1;
        pl_nx      = (pl_reg != '0) ? (pl_reg - 17'd1) : '0;
        quot_m1    = quot - 32'd1;
        // first payload also carries the four size bytes
        cap_first   = mc_reg - 16'd4;
        chunk_first = (size_reg < {15'd0, cap_first}) ? size_reg[MP_W-1:0] : cap_first;
    end

    assign stat.mp_small  = (mp_reg <= MP_MIN);
    assign stat.div_done  = div_done;
    assign stat.count_ok  = (quot[NUM_W-1:CNT_W] == '0) &&
                            (!quot[CNT_W-1] || (quot[CNT_W-2:0] == '0));
    assign stat.au_live   = active_reg && (au_left_reg != '0);
    assign stat.in_packet = in_pkt_reg;
    assign stat.out_free  = !ovalid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mp_reg      <= MP_RESET;
            pl_reg      <= '0;
            chunk_reg   <= '0;
            au_left_reg <= '0;
            first_reg   <= 1'b0;
            active_reg  <= 1'b0;
            in_pkt_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mp_reg <= cfg_wdata;
            end
            if (cmd.start_begin || cmd.drop_begin)
            begin
                pl_reg      <= '0;
                chunk_reg   <= '0;
                au_left_reg <= '0;
                first_reg   <= 1'b0;
                active_reg  <= 1'b0;
                in_pkt_reg  <= 1'b0;
            end
            else if (cmd.finish_begin)
            begin
                pl_reg      <= quot_m1[CNT_W-1:0];
                chunk_reg   <= chunk_first;
                au_left_reg <= size_reg;
                first_reg   <= 1'b1;
                active_reg  <= (size_reg != '0);
                in_pkt_reg  <= (size_reg != '0);
            end
            else if (cmd.take_data)
            begin
                if (!in_pkt_reg)
                begin
                    pl_reg    <= pl_nx;
                    first_reg <= 1'b0;
                end
                chunk_reg   <= chunk_nx;
                au_left_reg <= au_nx;
                active_reg  <= (au_nx != '0);
                in_pkt_reg  <= (au_nx != '0) && !d_end;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_begin)
        begin
            size_reg <= in_size;
            mc_reg   <= div_den;
        end
        if (cmd.finish_begin)
        begin
            hdr_b0_reg   <= hdr_byte((quot_m1[CNT_W-1:0] == '0) ? TYPE_LAST : TYPE_FIRST);
            hdr_cnt_reg  <= quot_m1[15:0];
            hdr_mark_reg <= 1'b1;
        end
        else if (cmd.take_data)
        begin
            if (!in_pkt_reg)
            begin
                hdr_b0_reg   <= hdr_byte((pl_nx == '0) ? TYPE_LAST : TYPE_MIDDLE);
                hdr_cnt_reg  <= pl_nx[15:0];
                hdr_mark_reg <= 1'b0;
            end
            data_reg      <= in_byte;
            data_end_reg  <= d_end;
            data_mark_reg <= d_mark;
        end
    end

    always_comb
    begin
        sel_start = 1'b0;
        sel_end   = 1'b0;
        sel_mark  = 1'b1;
        sel_byte  = data_reg;
        case (cmd.out_sel)
            OSEL_HDR0:
            begin
                sel_byte  = hdr_b0_reg;
                sel_start = 1'b1;
                sel_mark  = hdr_mark_reg;
            end
            OSEL_HDR1:
            begin
                sel_byte = hdr_cnt_reg[15:8];
                sel_mark = hdr_mark_reg;
            end
            OSEL_HDR2:
            begin
                sel_byte = hdr_cnt_reg[7:0];
                sel_mark = hdr_mark_reg;
            end
            OSEL_SZ0: sel_byte = {1'b0, size_reg[30:24]};
            OSEL_SZ1: sel_byte = size_reg[23:16];
            OSEL_SZ2: sel_byte = size_reg[15:8];
            OSEL_SZ3:
            begin
                sel_byte = size_reg[7:0];
                // empty unit closes its only payload on the last size byte
                sel_end  = (size_reg == '0);
            end
            OSEL_DATA:
            begin
                // direct path sends the incoming byte in its accept cycle
                sel_byte = cmd.out_direct ? in_byte : data_reg;
                sel_end  = cmd.out_direct ? d_end : data_end_reg;
                sel_mark = cmd.out_direct ? d_mark : data_mark_reg;
            end
            default:
            begin
                sel_byte = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            obyte_reg  <= sel_byte;
            ostart_reg <= sel_start;
            oend_reg   <= sel_end;
            omark_reg  <= sel_mark;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_byte  = obyte_reg;
    assign out_start = ostart_reg;
    assign out_end   = oend_reg;
    assign out_mark  = omark_reg;

endmodule

### hdl/rtpaf_ctrl.sv
// fragmenter controller: input acceptance and output byte sequencing
`timescale 1ns / 1ps

module rtpaf_ctrl
    import rtpaf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_op,
    output logic      in_ready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DIV  = 4'd1;
    localparam logic [3:0] ST_HDR0 = 4'd2;
    localparam logic [3:0] ST_HDR1 = 4'd3;
    localparam logic [3:0] ST_HDR2 = 4'd4;
    localparam logic [3:0] ST_SZ0  = 4'd5;
    localparam logic [3:0] ST_SZ1  = 4'd6;
    localparam logic [3:0] ST_SZ2  = 4'd7;
    localparam logic [3:0] ST_SZ3  = 4'd8;
    localparam logic [3:0] ST_DATA = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       first_hdr_reg, first_hdr_next;
    logic       acc;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        first_hdr_next = first_hdr_reg;
        in_ready       = (state_reg == ST_IDLE) && stat.out_free;
        acc            = in_valid && in_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    if (in_op == OP_BEGIN)
                    begin
                        if (stat.mp_small)
                        begin
                            cmd.drop_begin = 1'b1;
                        end
                        else
                        begin
                            cmd.start_begin = 1'b1;
                            state_next      = ST_DIV;
                        end
                    end
                    else if (stat.au_live)
                    begin
                        cmd.take_data = 1'b1;
                        if (stat.in_packet)
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.out_direct = 1'b1;
                            cmd.out_sel    = OSEL_DATA;
                        end
                        else
                        begin
                            first_hdr_next = 1'b0;
                            state_next     = ST_HDR0;
                        end
                    end
                end
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    if (stat.count_ok)
                    begin
                        cmd.finish_begin = 1'b1;
                        first_hdr_next   = 1'b1;
                        state_next       = ST_HDR0;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_HDR0:
            begin
                cmd.out_sel = OSEL_HDR0;
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_HDR1;
                end
            end
            ST_HDR1:
            begin
                cmd.out_sel = OSEL_HDR1;
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_HDR2;
                end
            end
            ST_HDR2:
            begin
                cmd.out_sel = OSEL_HDR2;
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = first_hdr_reg ? ST_SZ0 : ST_DATA;
                end
            end
            ST_SZ0:
            begin
                cmd.out_sel = OSEL_SZ0;
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_SZ1;
                end
            end
            ST_SZ1:
            begin
                cmd.out_sel = OSEL_SZ1;
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_SZ2;
                end
            end
            ST_SZ2:
            begin
                cmd.out_sel = OSEL_SZ2;
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_SZ3;
                end
            end
            ST_SZ3:
            begin
                cmd.out_sel = OSEL_SZ3;
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_DATA:
            begin
                cmd.out_sel = OSEL_DATA;
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            first_hdr_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            first_hdr_reg <= first_hdr_next;
        end
    end

endmodule
